// ===== sv/quadrature_position_sampler_core_assert.svh =====
// Assertion macros for the quadrature position sampler.
// Used by the top level only; needs no other file.
`ifndef QUADRATURE_POSITION_SAMPLER_CORE_ASSERT_SVH
`define QUADRATURE_POSITION_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qps assertion failed");

`endif

// ===== sv/qps_pkg.sv =====
// Shared types and constants for the quadrature position sampler.
// No dependencies; the design and testbench files use it by scoped names.
`timescale 1ns / 1ps

package qps_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned ENTRY_W  = 10;
    localparam int unsigned SIZE_W   = 11;
    localparam int unsigned CFG_W    = 32;

    localparam logic [TIME_W-1:0] RECORD_PERIOD_RESET = 32'd100000;
    localparam logic [SIZE_W-1:0] ENTRIES_RESET       = 11'd100;
    localparam logic [SIZE_W-1:0] ENTRIES_MAX         = 11'd1024;
    localparam logic [TIME_W:0]   TIMER_MAX           = 33'h0_FFFF_FFFF;

    localparam logic REG_RECORD_PERIOD = 1'b0;
    localparam logic REG_ENTRIES       = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] timer_count;
        logic              timer_wrapped;
        logic              pin_a;
        logic              pin_b;
        logic              pin_index;
        logic              pin_error;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  sample_time;
        logic [TIME_W-1:0]  wrap_total;
        logic [TIME_W-1:0]  position;
        logic               moving_down;
        logic               error_ok;
        logic               buffer_slot;
        logic [ENTRY_W-1:0] entry_slot;
        logic               buffer_last;
    } out_item_t;

    typedef struct packed {
        logic take;
        logic emit;
    } stage_ctl_t;

endpackage

// ===== sv/quadrature_position_sampler_core.sv =====
// Polls pass the input register; a due record then loads the result register.
// Throughput: one poll per cycle unless stalled; the decoder updates once per poll.
// Only a full result register that is not being drained stalls the input side.
// Reset (rst_n, asynchronous, active low) clears all decoder state, sets the error
// flag to normal and restores the record period to 100000 and the buffer size to 100.
// Depends on qps_pkg, qps_in_reg, qps_track, qps_out_reg and the assertion header.
`timescale 1ns / 1ps

`include "quadrature_position_sampler_core_assert.svh"

module quadrature_position_sampler_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  qps_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output qps_pkg::out_item_t              out_item,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [qps_pkg::CFG_W-1:0]       cfg_data
);

    logic [qps_pkg::TIME_W-1:0] record_period_reg;
    logic [qps_pkg::SIZE_W-1:0] entries_reg;

    logic                       item_valid;
    qps_pkg::in_item_t          item;
    qps_pkg::stage_ctl_t        ctl;
    qps_pkg::out_item_t         rec;
    logic                       out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_period_reg <= qps_pkg::RECORD_PERIOD_RESET;
            entries_reg       <= qps_pkg::ENTRIES_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                qps_pkg::REG_RECORD_PERIOD:
                begin
                    record_period_reg <= cfg_data[qps_pkg::TIME_W-1:0];
                end
                qps_pkg::REG_ENTRIES:
                begin
                    entries_reg <= cfg_data[qps_pkg::SIZE_W-1:0];
                end
                default:
                begin
                    record_period_reg <= record_period_reg;
                end
            endcase
        end
    end

    qps_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .ctl        (ctl),
        .item_valid (item_valid),
        .item       (item)
    );

    qps_track u_track
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_valid         (item_valid),
        .item               (item),
        .out_free           (out_free),
        .record_period      (record_period_reg),
        .entries_per_buffer (entries_reg),
        .ctl                (ctl),
        .rec                (rec)
    );

    qps_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rec       (rec),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    `QPS_ASSERT_NOW(a_emit_has_room, clk, rst_n, ctl.emit, ctl.take && (!out_valid || out_ready))
    `QPS_ASSERT_NOW(a_slot_max_is_last, clk, rst_n,
        out_valid && (out_item.entry_slot == 10'd1023), out_item.buffer_last)
    `QPS_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_valid && in_ready, item_valid)
    `QPS_ASSERT_NOW(a_empty_stage_ready, clk, rst_n, !item_valid, in_ready)

endmodule

// ===== sv/qps_in_reg.sv =====
// Input register of the quadrature position sampler.
// Depends on qps_pkg for the input item type and stage control struct.
`timescale 1ns / 1ps

module qps_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qps_pkg::in_item_t   in_item,
    input  qps_pkg::stage_ctl_t ctl,
    output logic                item_valid,
    output qps_pkg::in_item_t   item
);

    logic              valid_reg;
    logic              valid_next;
    qps_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || ctl.take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (ctl.take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== sv/qps_track.sv =====
// Decoder state and record logic of the quadrature position sampler.
// Depends on qps_pkg for item types, constants and the stage control struct.
`timescale 1ns / 1ps

module qps_track
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    input  qps_pkg::in_item_t                     item,
    input  logic                                  out_free,
    input  logic [qps_pkg::TIME_W-1:0]            record_period,
    input  logic [qps_pkg::SIZE_W-1:0]            entries_per_buffer,
    output qps_pkg::stage_ctl_t                   ctl,
    output qps_pkg::out_item_t                    rec
);

    logic                          primed_reg;
    logic                          primed_next;
    logic                          last_a_reg;
    logic                          last_a_next;
    logic [qps_pkg::TIME_W-1:0]    last_time_reg;
    logic [qps_pkg::TIME_W-1:0]    last_time_next;
    logic                          wrap_pending_reg;
    logic                          wrap_pending_next;
    logic [qps_pkg::TIME_W-1:0]    wrap_count_reg;
    logic [qps_pkg::TIME_W-1:0]    wrap_count_next;
    logic [qps_pkg::TIME_W-1:0]    position_reg;
    logic [qps_pkg::TIME_W-1:0]    position_next;
    logic                          direction_reg;
    logic                          direction_next;
    logic                          error_seen_reg;
    logic                          error_seen_next;
    logic                          buffer_reg;
    logic                          buffer_next;
    logic [qps_pkg::ENTRY_W-1:0]   entry_reg;
    logic [qps_pkg::ENTRY_W-1:0]   entry_next;

    logic                          pending_eff;
    logic [qps_pkg::TIME_W:0]      span;
    logic                          due_pending;
    logic                          due_plain;
    logic                          due;
    logic [qps_pkg::TIME_W-1:0]    wrap_total;
    logic [qps_pkg::SIZE_W-1:0]    size;
    logic [qps_pkg::SIZE_W-1:0]    entry_inc;
    logic                          last;
    logic [qps_pkg::TIME_W-1:0]    position_base;

    assign pending_eff = wrap_pending_reg || item.timer_wrapped;
    assign span        = {1'b0, item.timer_count} - {1'b0, last_time_reg} + qps_pkg::TIMER_MAX;
    assign due_pending = {1'b0, record_period} <= span;
    assign due_plain   = ({1'b0, last_time_reg} + {1'b0, record_period})
                         <= {1'b0, item.timer_count};
    assign due         = primed_reg && (pending_eff ? due_pending : due_plain);
    assign wrap_total  = wrap_count_reg + {{(qps_pkg::TIME_W-1){1'b0}}, item.timer_wrapped};

    always_comb
    begin
        if (entries_per_buffer == '0)
        begin
            size = {{(qps_pkg::SIZE_W-1){1'b0}}, 1'b1};
        end
        else if (entries_per_buffer > qps_pkg::ENTRIES_MAX)
        begin
            size = qps_pkg::ENTRIES_MAX;
        end
        else
        begin
            size = entries_per_buffer;
        end
    end

    assign entry_inc = {1'b0, entry_reg} + {{(qps_pkg::SIZE_W-1){1'b0}}, 1'b1};
    assign last      = entry_inc >= size;

    assign ctl.take = item_valid && out_free;
    assign ctl.emit = item_valid && out_free && due;

    assign rec.sample_time = item.timer_count;
    assign rec.wrap_total  = wrap_total;
    assign rec.position    = position_reg;
    assign rec.moving_down = direction_reg;
    assign rec.error_ok    = error_seen_reg;
    assign rec.buffer_slot = buffer_reg;
    assign rec.entry_slot  = entry_reg;
    assign rec.buffer_last = last;

    assign position_base = item.pin_index ? '0 : position_reg;

    always_comb
    begin
        primed_next       = primed_reg;
        last_a_next       = last_a_reg;
        last_time_next    = last_time_reg;
        wrap_pending_next = wrap_pending_reg;
        wrap_count_next   = wrap_count_reg;
        position_next     = position_reg;
        direction_next    = direction_reg;
        error_seen_next   = error_seen_reg;
        buffer_next       = buffer_reg;
        entry_next        = entry_reg;
        if (ctl.take)
        begin
            if (!primed_reg)
            begin
                primed_next    = 1'b1;
                last_a_next    = item.pin_a;
                last_time_next = item.timer_count;
            end
            else
            begin
                wrap_count_next   = wrap_total;
                wrap_pending_next = pending_eff && !due;
                if (due)
                begin
                    last_time_next = item.timer_count;
                    if (last)
                    begin
                        entry_next  = '0;
                        buffer_next = !buffer_reg;
                    end
                    else
                    begin
                        entry_next = entry_inc[qps_pkg::ENTRY_W-1:0];
                    end
                end
                error_seen_next = item.pin_error;
                position_next   = position_base;
                if (item.pin_a != last_a_reg)
                begin
                    last_a_next = item.pin_a;
                    if (item.pin_a ^ item.pin_b)
                    begin
                        direction_next = 1'b0;
                        position_next  = position_base + 32'd1;
                    end
                    else
                    begin
                        direction_next = 1'b1;
                        position_next  = position_base - 32'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg       <= 1'b0;
            last_a_reg       <= 1'b0;
            last_time_reg    <= '0;
            wrap_pending_reg <= 1'b0;
            wrap_count_reg   <= '0;
            position_reg     <= '0;
            direction_reg    <= 1'b0;
            error_seen_reg   <= 1'b1;
            buffer_reg       <= 1'b0;
            entry_reg        <= '0;
        end
        else
        begin
            primed_reg       <= primed_next;
            last_a_reg       <= last_a_next;
            last_time_reg    <= last_time_next;
            wrap_pending_reg <= wrap_pending_next;
            wrap_count_reg   <= wrap_count_next;
            position_reg     <= position_next;
            direction_reg    <= direction_next;
            error_seen_reg   <= error_seen_next;
            buffer_reg       <= buffer_next;
            entry_reg        <= entry_next;
        end
    end

endmodule

// ===== sv/qps_out_reg.sv =====
// Result register of the quadrature position sampler.
// Depends on qps_pkg for the output item type and stage control struct.
`timescale 1ns / 1ps

module qps_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  qps_pkg::stage_ctl_t ctl,
    input  qps_pkg::out_item_t  rec,
    output logic                out_free,
    output logic                out_valid,
    input  logic                out_ready,
    output qps_pkg::out_item_t  out_item
);

    logic               valid_reg;
    logic               valid_next;
    qps_pkg::out_item_t item_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            item_reg <= rec;
        end
    end

endmodule

// ===== verif/tb_quadrature_position_sampler_core.sv =====
// Testbench for quadrature_position_sampler_core: directed and random encoder polls,
// with a poll-level record predictor and an in-order record checker.
// Depends on qps_pkg and the quadrature_position_sampler_core RTL.
`timescale 1ns / 1ps

module tb_quadrature_position_sampler_core;

    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES  = 8;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    qps_pkg::in_item_t           in_item;
    logic                        out_valid;
    logic                        out_ready;
    qps_pkg::out_item_t          out_item;
    logic                        cfg_wr_en;
    logic                        cfg_index;
    logic [qps_pkg::CFG_W-1:0]   cfg_data;

    logic [qps_pkg::TIME_W-1:0]  interval_reg;
    logic [qps_pkg::SIZE_W-1:0]  entries_reg;
    logic                        armed;
    logic                        prev_a;
    logic [qps_pkg::TIME_W-1:0]  mark_time;
    logic                        wrap_armed;
    logic [qps_pkg::TIME_W-1:0]  wraps;
    logic [qps_pkg::TIME_W-1:0]  pos_count;
    logic                        dir_down;
    logic                        err_prev;
    logic                        half_sel;
    logic [qps_pkg::ENTRY_W-1:0] fill_idx;

    qps_pkg::out_item_t          pending_records[$];
    int unsigned                 mismatches;
    int unsigned                 idle_cycles;
    logic                        gap_en;
    logic                        stall_en;
    logic [qps_pkg::TIME_W-1:0]  tick;
    int unsigned                 quad_phase;
    int unsigned                 hold;

    quadrature_position_sampler_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void predict_poll(input qps_pkg::in_item_t p);
        logic [qps_pkg::TIME_W:0]   span;
        logic                       due;
        logic [qps_pkg::SIZE_W-1:0] half_len;
        qps_pkg::out_item_t         rec;
        due = 1'b0;
        if (!armed)
        begin
            armed     = 1'b1;
            prev_a    = p.pin_a;
            mark_time = p.timer_count;
            return;
        end
        if (p.timer_wrapped)
        begin
            wraps      = wraps + 32'd1;
            wrap_armed = 1'b1;
        end
        if (wrap_armed)
        begin
            span = {1'b0, p.timer_count} + qps_pkg::TIMER_MAX - {1'b0, mark_time};
            if ({1'b0, interval_reg} <= span)
            begin
                due        = 1'b1;
                wrap_armed = 1'b0;
            end
        end
        else
        begin
            due = ({1'b0, mark_time} + {1'b0, interval_reg}) <= {1'b0, p.timer_count};
        end
        if (due)
        begin
            if (entries_reg == '0)
                half_len = 11'd1;
            else if (entries_reg > qps_pkg::ENTRIES_MAX)
                half_len = qps_pkg::ENTRIES_MAX;
            else
                half_len = entries_reg;
            rec.sample_time = p.timer_count;
            rec.wrap_total  = wraps;
            rec.position    = pos_count;
            rec.moving_down = dir_down;
            rec.error_ok    = err_prev;
            rec.buffer_slot = half_sel;
            rec.entry_slot  = fill_idx;
            rec.buffer_last = ({1'b0, fill_idx} + 11'd1) >= half_len;
            pending_records.push_back(rec);
            mark_time = p.timer_count;
            if (rec.buffer_last)
            begin
                fill_idx = '0;
                half_sel = ~half_sel;
            end
            else
            begin
                fill_idx = fill_idx + 1'b1;
            end
        end
        err_prev = p.pin_error;
        if (p.pin_index)
            pos_count = '0;
        if (p.pin_a != prev_a)
        begin
            if (p.pin_a ^ p.pin_b)
            begin
                dir_down  = 1'b0;
                pos_count = pos_count + 32'd1;
            end
            else
            begin
                dir_down  = 1'b1;
                pos_count = pos_count - 32'd1;
            end
            prev_a = p.pin_a;
        end
    endfunction

    function automatic void report_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_record(input qps_pkg::out_item_t got);
        qps_pkg::out_item_t want;
        if (pending_records.size() == 0)
        begin
            $display("%0t: unexpected record, expected none actual %p", $time, got);
            mismatches++;
            return;
        end
        want = pending_records.pop_front();
        report_field("sample_time", want.sample_time, got.sample_time);
        report_field("wrap_total", want.wrap_total, got.wrap_total);
        report_field("position", want.position, got.position);
        report_field("moving_down", 32'(want.moving_down), 32'(got.moving_down));
        report_field("error_ok", 32'(want.error_ok), 32'(got.error_ok));
        report_field("buffer_slot", 32'(want.buffer_slot), 32'(got.buffer_slot));
        report_field("entry_slot", 32'(want.entry_slot), 32'(got.entry_slot));
        report_field("buffer_last", 32'(want.buffer_last), 32'(got.buffer_last));
    endfunction

    // Sampling on the falling edge sees the values that the next rising edge accepts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_poll(in_item);
            if (out_valid && out_ready)
                check_record(out_item);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("** quadrature_position_sampler_core: FAILED **");
        $finish;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    initial
    begin
        out_ready = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
            begin
                hold--;
            end
            else if (!stall_en || !out_ready)
            begin
                out_ready <= 1'b1;
                hold = $urandom_range(20);
            end
            else
            begin
                out_ready <= 1'b0;
                hold = idle_len();
            end
        end
    end

    function automatic qps_pkg::in_item_t mk_poll(input logic [31:0] ts, input logic wrapped,
                                                  input logic a, input logic b,
                                                  input logic idx, input logic err);
        qps_pkg::in_item_t p;
        p.timer_count   = ts;
        p.timer_wrapped = wrapped;
        p.pin_a         = a;
        p.pin_b         = b;
        p.pin_index     = idx;
        p.pin_error     = err;
        return p;
    endfunction

    function automatic qps_pkg::in_item_t random_poll();
        qps_pkg::in_item_t        p;
        logic [31:0]              step;
        logic [qps_pkg::TIME_W:0] sum;
        int unsigned              r;
        if ($urandom_range(99) < 12)
        begin
            return mk_poll($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
        end
        r = $urandom_range(99);
        if (r < 85)
            step = $urandom_range(15);
        else if (r < 95)
            step = $urandom_range(1000, 16);
        else
            step = $urandom;
        sum  = {1'b0, tick} + {1'b0, step};
        tick = sum[qps_pkg::TIME_W-1:0];
        r = $urandom_range(9);
        if (r >= 7)
            quad_phase = (quad_phase + 1) % 4;
        else if (r >= 4)
            quad_phase = (quad_phase + 3) % 4;
        p = mk_poll(tick, sum[qps_pkg::TIME_W], (quad_phase == 1) || (quad_phase == 2),
                    quad_phase >= 2, $urandom_range(39) == 0, $urandom_range(19) != 0);
        return p;
    endfunction

    task automatic send_poll(input qps_pkg::in_item_t p);
        int unsigned gap;
        logic        taken;
        gap = gap_en ? idle_len() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= p;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [qps_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == qps_pkg::REG_RECORD_PERIOD)
            interval_reg = val;
        else
            entries_reg = val[qps_pkg::SIZE_W-1:0];
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) send_poll(random_poll());
        wait_idle();
    endtask

    task automatic test_first_poll_and_defaults();
        send_poll(mk_poll(32'd5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_poll(mk_poll(32'd100004, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(mk_poll(32'd100005, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_poll(mk_poll(32'd100006, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
        wait_idle();
    endtask

    task automatic test_extreme_settings();
        write_reg(qps_pkg::REG_RECORD_PERIOD, 32'hFFFF_FFFF);
        write_reg(qps_pkg::REG_ENTRIES, 32'd2047);
        send_poll(mk_poll(32'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_poll(mk_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        wait_idle();
        write_reg(qps_pkg::REG_RECORD_PERIOD, 32'd1);
        send_poll(mk_poll(32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_poll(mk_poll(32'd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        wait_idle();
    endtask

    task automatic test_zero_interval();
        write_reg(qps_pkg::REG_RECORD_PERIOD, 32'd0);
        write_reg(qps_pkg::REG_ENTRIES, 32'd0);
        send_poll(mk_poll(32'd10, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_poll(mk_poll(32'd10, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'd11, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_poll(mk_poll(32'd11, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        send_poll(mk_poll(32'd12, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_poll(mk_poll(32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        wait_idle();
    endtask

    task automatic test_entries_shrink();
        write_reg(qps_pkg::REG_ENTRIES, 32'd10);
        for (int i = 0; i < 5; i++)
            send_poll(mk_poll(32'd100 + i, 1'b0, i[0], 1'b0, 1'b0, 1'b1));
        wait_idle();
        write_reg(qps_pkg::REG_ENTRIES, 32'd3);
        send_poll(mk_poll(32'd200, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
        send_poll(mk_poll(32'd201, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        wait_idle();
    endtask

    task automatic test_random_small_buffers();
        tick = 32'hFFFF_F000;
        gap_en = 1'b1;
        stall_en = 1'b1;
        write_reg(qps_pkg::REG_RECORD_PERIOD, $urandom_range(40, 1));
        write_reg(qps_pkg::REG_ENTRIES, $urandom_range(8, 1));
        run_random(300);
    endtask

    task automatic test_random_full_buffer();
        write_reg(qps_pkg::REG_RECORD_PERIOD, 32'd0);
        write_reg(qps_pkg::REG_ENTRIES, 32'd1024);
        run_random(1100);
    endtask

    task automatic test_random_rare_records();
        write_reg(qps_pkg::REG_RECORD_PERIOD, 32'hFFFF_FFFF);
        write_reg(qps_pkg::REG_ENTRIES, 32'd2047);
        run_random(150);
    endtask

    task automatic test_random_back_to_back();
        gap_en = 1'b0;
        stall_en = 1'b0;
        write_reg(qps_pkg::REG_RECORD_PERIOD, $urandom_range(20, 1));
        write_reg(qps_pkg::REG_ENTRIES, 32'd0);
        run_random(300);
    endtask

    task automatic test_random_mixed();
        gap_en = 1'b1;
        stall_en = 1'b1;
        write_reg(qps_pkg::REG_RECORD_PERIOD, $urandom_range(60, 1));
        write_reg(qps_pkg::REG_ENTRIES, $urandom_range(16, 2));
        run_random(300);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = qps_pkg::REG_RECORD_PERIOD;
        cfg_data     = '0;
        interval_reg = qps_pkg::RECORD_PERIOD_RESET;
        entries_reg  = qps_pkg::ENTRIES_RESET;
        armed        = 1'b0;
        prev_a       = 1'b0;
        mark_time    = '0;
        wrap_armed   = 1'b0;
        wraps        = '0;
        pos_count    = '0;
        dir_down     = 1'b0;
        err_prev     = 1'b1;
        half_sel     = 1'b0;
        fill_idx     = '0;
        mismatches   = 0;
        gap_en       = 1'b1;
        stall_en     = 1'b1;
        tick         = '0;
        quad_phase   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_poll_and_defaults();
        test_extreme_settings();
        test_zero_interval();
        test_entries_shrink();
        test_random_small_buffers();
        test_random_full_buffer();
        test_random_rare_records();
        test_random_back_to_back();
        test_random_mixed();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_records.size() == 0)
            $display("** quadrature_position_sampler_core: PASSED **");
        else
            $display("** quadrature_position_sampler_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/qps_pkg.sv
sv/qps_in_reg.sv
sv/qps_track.sv
sv/qps_out_reg.sv
sv/quadrature_position_sampler_core.sv
verif/tb_quadrature_position_sampler_core.sv
